// File: rtl/core/planar_yaw_pose_transform_assert.svh
// Assertion macros used by the pose transform checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef PLANAR_YAW_POSE_TRANSFORM_ASSERT_SVH
`define PLANAR_YAW_POSE_TRANSFORM_ASSERT_SVH

// Same-cycle implication.
`define PYT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pyt check failed: same-cycle implication");

// Next-cycle implication.
`define PYT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pyt check failed: next-cycle implication");

`endif

// File: rtl/core/pyt_pkg.sv
// Shared types, constants and saturation helpers for the planar yaw pose transform.
// No dependencies; every other file of the block but the assertion header imports this package.
package pyt_pkg;

  localparam int TRIG_ITERATIONS = 16;
  localparam int TABLE_LEN       = 24;
  localparam int NUM_ITER        = (TRIG_ITERATIONS < TABLE_LEN) ? TRIG_ITERATIONS : TABLE_LEN;
  localparam int ITER_W          = $clog2(NUM_ITER);
  localparam int TBL_W           = $clog2(TABLE_LEN);

  localparam int FUNC_W   = 2;
  localparam int ANGLE_W  = 17;
  localparam int COORD_W  = 32;
  localparam int TRIG_W   = 16;
  localparam int CORDIC_W = 18;
  localparam int Z_W      = 32;
  localparam int PROD_W   = TRIG_W + COORD_W;
  localparam int FRAC_SH  = 15;
  localparam int ZSCALE_SH = 13;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W   = 3;

  localparam logic signed [CORDIC_W-1:0] FULL_TURN    = 18'sd46080;
  localparam logic signed [CORDIC_W-1:0] HALF_TURN    = 18'sd23040;
  localparam logic signed [CORDIC_W-1:0] QUARTER_TURN = 18'sd11520;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN  = 18'sd19898;

  localparam logic signed [32:0] S32_MAX = 33'sd2147483647;
  localparam logic signed [32:0] S32_MIN = -33'sd2147483648;
  localparam logic signed [32:0] S16_MAX = 33'sd32767;
  localparam logic signed [32:0] S16_MIN = -33'sd32768;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ROTATE   = 2'd0,
    FUNC_MOVE     = 2'd1,
    FUNC_POINT    = 2'd2,
    FUNC_POSITION = 2'd3
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_CENTER_Z = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_TRIG_YAW,
    ST_TRIG_ELEV,
    ST_MOVE,
    ST_POINT,
    ST_POSITION,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic                      start;
    logic signed [ANGLE_W-1:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [TRIG_W-1:0] sin_v;
    logic signed [TRIG_W-1:0] cos_v;
  } cordic_rsp_t;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic signed [Z_W-1:0] atan_lut(input logic [TBL_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = 32'sd47185920;
      5'd1:    v = 32'sd27855475;
      5'd2:    v = 32'sd14718068;
      5'd3:    v = 32'sd7471121;
      5'd4:    v = 32'sd3750058;
      5'd5:    v = 32'sd1876857;
      5'd6:    v = 32'sd938658;
      5'd7:    v = 32'sd469357;
      5'd8:    v = 32'sd234682;
      5'd9:    v = 32'sd117342;
      5'd10:   v = 32'sd58671;
      5'd11:   v = 32'sd29335;
      5'd12:   v = 32'sd14668;
      5'd13:   v = 32'sd7334;
      5'd14:   v = 32'sd3667;
      5'd15:   v = 32'sd1833;
      5'd16:   v = 32'sd917;
      5'd17:   v = 32'sd458;
      5'd18:   v = 32'sd229;
      5'd19:   v = 32'sd115;
      5'd20:   v = 32'sd57;
      5'd21:   v = 32'sd29;
      5'd22:   v = 32'sd14;
      5'd23:   v = 32'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = 32'sh7FFFFFFF;
    end else if (v < S32_MIN) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
    logic signed [15:0] r;
    if (v > S16_MAX) begin
      r = 16'sh7FFF;
    end else if (v < S16_MIN) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/core/pyt_in_if.sv
// Input channel of the pose transform: valid/ready plus one command beat.
// Depends on pyt_pkg for field widths.
interface pyt_in_if import pyt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [ANGLE_W-1:0] angle;
  logic signed [COORD_W-1:0] distance;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;

  modport source (
    output valid, func, angle, distance, point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, func, angle, distance, point_x, point_y, point_z,
    output ready
  );
endinterface

// File: rtl/core/pyt_out_if.sv
// Output channel of the pose transform: valid/ready plus one result beat.
// Depends on pyt_pkg for field widths.
interface pyt_out_if import pyt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] out_x;
  logic signed [COORD_W-1:0] out_y;
  logic signed [COORD_W-1:0] out_z;
  logic signed [ANGLE_W-1:0] yaw_now;

  modport source (
    output valid, out_x, out_y, out_z, yaw_now,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, yaw_now,
    output ready
  );
endinterface

// File: rtl/core/pyt_cordic.sv
// Iterative rotation-mode CORDIC: angle in 1/128 degree to Q1.15 sine and cosine.
// One micro-rotation per cycle; depends on pyt_pkg.
module pyt_cordic import pyt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cordic_req_t req_i,
  output cordic_rsp_t rsp_o
);

  logic                       run_q, run_d;
  logic                       done_q, done_d;
  logic                       neg_q, neg_d;
  logic [ITER_W-1:0]          iter_q, iter_d;
  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d;
  logic signed [Z_W-1:0]      z_q, z_d;

  logic signed [CORDIC_W-1:0] a, r0, r1, r2;
  logic                       fold;
  logic signed [CORDIC_W-1:0] dx, dy;
  logic signed [Z_W-1:0]      atan_v;
  logic signed [TRIG_W-1:0]   cos_pos;

  // Reduce to [-90, 90] degrees, folding through 180 with cosine negated.
  always_comb begin
    a = CORDIC_W'(req_i.angle);
    if (a < 0) begin
      r0 = a + FULL_TURN;
      if (r0 < 0) begin
        r0 = r0 + FULL_TURN;
      end
    end else if (a >= FULL_TURN) begin
      r0 = a - FULL_TURN;
    end else begin
      r0 = a;
    end
    r1 = (r0 >= HALF_TURN) ? r0 - FULL_TURN : r0;
    fold = 1'b0;
    if (r1 > QUARTER_TURN) begin
      r2   = HALF_TURN - r1;
      fold = 1'b1;
    end else if (r1 < -QUARTER_TURN) begin
      r2   = -HALF_TURN - r1;
      fold = 1'b1;
    end else begin
      r2 = r1;
    end
  end

  assign dx     = y_q >>> iter_q;
  assign dy     = x_q >>> iter_q;
  assign atan_v = atan_lut(TBL_W'(iter_q));

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    neg_d  = neg_q;
    iter_d = iter_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (run_q) begin
      if (!z_q[Z_W-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_v;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_v;
      end
      iter_d = iter_q + 1'b1;
      if (iter_q == ITER_W'(NUM_ITER - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      run_d  = 1'b1;
      neg_d  = fold;
      iter_d = '0;
      x_d    = CORDIC_GAIN;
      y_d    = '0;
      z_d    = Z_W'(r2) <<< ZSCALE_SH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    iter_q <= iter_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign cos_pos     = sat16(33'(x_q));
  assign rsp_o.done  = done_q;
  assign rsp_o.sin_v = sat16(33'(y_q));
  assign rsp_o.cos_v = neg_q ? sat16(-(33'(cos_pos))) : cos_pos;

endmodule

// File: rtl/core/planar_yaw_pose_transform.sv
// Planar yaw pose transform: keeps a body pose (yaw in 1/128 degree, Q16.16 offset)
// and serves rotate, move, point-transform and position commands one at a time.
// Depends on pyt_pkg, pyt_in_if, pyt_out_if and pyt_cordic.
//
// One command beat in, one result beat out. in_i.ready is high only while the
// sequencer is idle; a finished result sits in an output register, so the next
// command is taken while the previous result still waits on out_o. Another
// command can be accepted in the cycle after the result is loaded. The CORDIC
// unit does one micro-rotation per cycle and runs once per sine/cosine pair
// (twice for move: yaw, then elevation); the sequencer steps the single shared
// multiplier and saturating adder through one product and one sum per cycle.
// Center registers are written on cfg_we_i by index (0 x, 1 y, 2 z); index 3 is
// dropped. Write them only while the block is idle.
module planar_yaw_pose_transform import pyt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [COORD_W-1:0]    cfg_data_i,
  pyt_in_if.sink                in_i,
  pyt_out_if.source             out_o
);

  // Sequencer
  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;

  // Captured command beat
  func_e                     func_q, func_d;
  logic signed [ANGLE_W-1:0] ang_q, ang_d;
  logic signed [COORD_W-1:0] dist_q, dist_d;
  logic signed [COORD_W-1:0] px_q, px_d, py_q, py_d, pz_q, pz_d;

  // Pose and configuration
  logic signed [ANGLE_W-1:0] yaw_q, yaw_d;
  logic signed [COORD_W-1:0] off0_q, off0_d, off1_q, off1_d, off2_q, off2_d;
  logic signed [COORD_W-1:0] ctr_x_q, ctr_x_d, ctr_y_q, ctr_y_d, ctr_z_q, ctr_z_d;

  // Working registers
  logic signed [TRIG_W-1:0]  sy_q, sy_d, cy_q, cy_d, se_q, se_d, ce_q, ce_d;
  logic signed [TRIG_W-1:0]  dir0_q, dir0_d, dir1_q, dir1_d;
  logic signed [COORD_W-1:0] t_q, t_d, u_q, u_d;
  logic signed [COORD_W-1:0] res0_q, res0_d, res1_q, res1_d, res2_q, res2_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;

  // Output register
  logic                      out_valid_q, out_valid_d;
  logic signed [COORD_W-1:0] out_x_q, out_x_d, out_y_q, out_y_d, out_z_q, out_z_d;
  logic signed [ANGLE_W-1:0] out_yaw_q, out_yaw_d;

  // Shared datapath
  logic signed [TRIG_W-1:0]  mul_a;
  logic signed [COORD_W-1:0] mul_b;
  logic signed [32:0]        p15;
  logic signed [COORD_W-1:0] p15_s32;
  logic signed [TRIG_W-1:0]  p15_s16;
  logic signed [COORD_W-1:0] add_a, add_b, add_y;
  logic                      add_sub;

  // Yaw wrap
  logic signed [CORDIC_W-1:0] ysum, ywrap1, ywrap2;

  logic        in_accept;
  logic        out_load;
  cordic_req_t cordic_req;
  cordic_rsp_t cordic_rsp;

  pyt_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cordic_req),
    .rsp_o  (cordic_rsp)
  );

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_accept  = in_i.valid && in_i.ready;

  // One signed multiply per cycle; the Q1.15 product is taken from the register.
  assign prod_d  = mul_a * mul_b;
  assign p15     = prod_q[PROD_W-1:FRAC_SH];
  assign p15_s32 = sat32(p15);
  assign p15_s16 = sat16(p15);

  // One saturating add or subtract per cycle.
  assign add_y = add_sub ? sat32(33'(add_a) - 33'(add_b)) : sat32(33'(add_a) + 33'(add_b));

  // Wrap the yaw sum into the open interval (-360, 360) degrees; two steps cover
  // every 17-bit delta.
  always_comb begin
    ysum = CORDIC_W'(yaw_q) + CORDIC_W'(ang_q);
    if (ysum >= FULL_TURN) begin
      ywrap1 = ysum - FULL_TURN;
    end else if (ysum <= -FULL_TURN) begin
      ywrap1 = ysum + FULL_TURN;
    end else begin
      ywrap1 = ysum;
    end
    if (ywrap1 >= FULL_TURN) begin
      ywrap2 = ywrap1 - FULL_TURN;
    end else if (ywrap1 <= -FULL_TURN) begin
      ywrap2 = ywrap1 + FULL_TURN;
    end else begin
      ywrap2 = ywrap1;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    func_d  = func_q;
    ang_d   = ang_q;
    dist_d  = dist_q;
    px_d    = px_q;
    py_d    = py_q;
    pz_d    = pz_q;
    yaw_d   = yaw_q;
    off0_d  = off0_q;
    off1_d  = off1_q;
    off2_d  = off2_q;
    ctr_x_d = ctr_x_q;
    ctr_y_d = ctr_y_q;
    ctr_z_d = ctr_z_q;
    sy_d    = sy_q;
    cy_d    = cy_q;
    se_d    = se_q;
    ce_d    = ce_q;
    dir0_d  = dir0_q;
    dir1_d  = dir1_q;
    t_d     = t_q;
    u_d     = u_q;
    res0_d  = res0_q;
    res1_d  = res1_q;
    res2_d  = res2_q;
    mul_a   = '0;
    mul_b   = '0;
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b0;
    out_load = 1'b0;
    cordic_req = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          func_d = func_e'(in_i.func);
          ang_d  = in_i.angle;
          dist_d = in_i.distance;
          px_d   = in_i.point_x;
          py_d   = in_i.point_y;
          pz_d   = in_i.point_z;
          step_d = '0;
          case (func_e'(in_i.func))
            FUNC_ROTATE: begin
              state_d = ST_ROTATE;
            end
            FUNC_MOVE, FUNC_POINT: begin
              // Start the yaw sine/cosine right away.
              cordic_req.start = 1'b1;
              cordic_req.angle = yaw_q;
              state_d          = ST_TRIG_YAW;
            end
            default: begin
              state_d = ST_POSITION;
            end
          endcase
        end
      end

      ST_ROTATE: begin
        yaw_d   = ywrap2[ANGLE_W-1:0];
        res0_d  = off0_q;
        res1_d  = off1_q;
        res2_d  = off2_q;
        state_d = ST_DONE;
      end

      ST_TRIG_YAW: begin
        if (cordic_rsp.done) begin
          sy_d   = cordic_rsp.sin_v;
          cy_d   = cordic_rsp.cos_v;
          step_d = '0;
          if (func_q == FUNC_MOVE) begin
            // Chain the elevation pass behind the yaw pass.
            cordic_req.start = 1'b1;
            cordic_req.angle = ang_q;
            state_d          = ST_TRIG_ELEV;
          end else begin
            state_d = ST_POINT;
          end
        end
      end

      ST_TRIG_ELEV: begin
        if (cordic_rsp.done) begin
          se_d    = cordic_rsp.sin_v;
          ce_d    = cordic_rsp.cos_v;
          step_d  = '0;
          state_d = ST_MOVE;
        end
      end

      // dir = (cy*ce, sy*ce, se); offset += dir * distance, component by component.
      ST_MOVE: begin
        step_d = step_q + 1'b1;
        case (step_q)
          3'd0: begin
            mul_a = cy_q;
            mul_b = COORD_W'(ce_q);
          end
          3'd1: begin
            dir0_d = p15_s16;
            mul_a  = sy_q;
            mul_b  = COORD_W'(ce_q);
          end
          3'd2: begin
            dir1_d = p15_s16;
            mul_a  = dir0_q;
            mul_b  = dist_q;
          end
          3'd3: begin
            add_a  = off0_q;
            add_b  = p15_s32;
            off0_d = add_y;
            res0_d = add_y;
            mul_a  = dir1_q;
            mul_b  = dist_q;
          end
          3'd4: begin
            add_a  = off1_q;
            add_b  = p15_s32;
            off1_d = add_y;
            res1_d = add_y;
            mul_a  = se_q;
            mul_b  = dist_q;
          end
          3'd5: begin
            add_a   = off2_q;
            add_b   = p15_s32;
            off2_d  = add_y;
            res2_d  = add_y;
            state_d = ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      // x' = c*px - s*py + ox, y' = s*px + c*py + oy, z' = pz + oz.
      ST_POINT: begin
        step_d = step_q + 1'b1;
        case (step_q)
          3'd0: begin
            mul_a = cy_q;
            mul_b = px_q;
          end
          3'd1: begin
            t_d   = p15_s32;
            mul_a = sy_q;
            mul_b = py_q;
          end
          3'd2: begin
            add_a   = t_q;
            add_b   = p15_s32;
            add_sub = 1'b1;
            t_d     = add_y;
            mul_a   = sy_q;
            mul_b   = px_q;
          end
          3'd3: begin
            add_a  = t_q;
            add_b  = off0_q;
            res0_d = add_y;
            u_d    = p15_s32;
            mul_a  = cy_q;
            mul_b  = py_q;
          end
          3'd4: begin
            add_a = u_q;
            add_b = p15_s32;
            u_d   = add_y;
          end
          3'd5: begin
            add_a  = u_q;
            add_b  = off1_q;
            res1_d = add_y;
          end
          3'd6: begin
            add_a   = pz_q;
            add_b   = off2_q;
            res2_d  = add_y;
            state_d = ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end

      ST_POSITION: begin
        step_d = step_q + 1'b1;
        case (step_q)
          3'd0: begin
            add_a  = ctr_x_q;
            add_b  = off0_q;
            res0_d = add_y;
          end
          3'd1: begin
            add_a  = ctr_y_q;
            add_b  = off1_q;
            res1_d = add_y;
          end
          default: begin
            add_a   = ctr_z_q;
            add_b   = off2_q;
            res2_d  = add_y;
            state_d = ST_DONE;
          end
        endcase
      end

      ST_DONE: begin
        // Hold until the output register is free or being drained.
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_CENTER_X: ctr_x_d = cfg_data_i;
        CFG_CENTER_Y: ctr_y_d = cfg_data_i;
        CFG_CENTER_Z: ctr_z_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Output register: load on completion, drop on a taken beat.
  always_comb begin
    out_valid_d = out_valid_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_z_d     = out_z_q;
    out_yaw_d   = out_yaw_q;
    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
      out_x_d     = res0_q;
      out_y_d     = res1_q;
      out_z_d     = res2_q;
      out_yaw_d   = yaw_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      yaw_q       <= '0;
      off0_q      <= '0;
      off1_q      <= '0;
      off2_q      <= '0;
      ctr_x_q     <= '0;
      ctr_y_q     <= '0;
      ctr_z_q     <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      yaw_q       <= yaw_d;
      off0_q      <= off0_d;
      off1_q      <= off1_d;
      off2_q      <= off2_d;
      ctr_x_q     <= ctr_x_d;
      ctr_y_q     <= ctr_y_d;
      ctr_z_q     <= ctr_z_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q    <= func_d;
    ang_q     <= ang_d;
    dist_q    <= dist_d;
    px_q      <= px_d;
    py_q      <= py_d;
    pz_q      <= pz_d;
    sy_q      <= sy_d;
    cy_q      <= cy_d;
    se_q      <= se_d;
    ce_q      <= ce_d;
    dir0_q    <= dir0_d;
    dir1_q    <= dir1_d;
    t_q       <= t_d;
    u_q       <= u_d;
    res0_q    <= res0_d;
    res1_q    <= res1_d;
    res2_q    <= res2_d;
    prod_q    <= prod_d;
    out_x_q   <= out_x_d;
    out_y_q   <= out_y_d;
    out_z_q   <= out_z_d;
    out_yaw_q <= out_yaw_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.out_x   = out_x_q;
  assign out_o.out_y   = out_y_q;
  assign out_o.out_z   = out_z_q;
  assign out_o.yaw_now = out_yaw_q;

endmodule

// File: rtl/core/pyt_checker.sv
// Port-level checker for the planar yaw pose transform, attached by bind.
// Depends on pyt_pkg and planar_yaw_pose_transform_assert.svh.
`include "planar_yaw_pose_transform_assert.svh"

module pyt_checker import pyt_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic signed [COORD_W-1:0] out_x_i,
  input logic signed [COORD_W-1:0] out_y_i,
  input logic signed [COORD_W-1:0] out_z_i,
  input logic signed [ANGLE_W-1:0] out_yaw_now_i
);

  // A stalled result beat stays put.
  `PYT_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `PYT_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(out_x_i) && $stable(out_y_i) && $stable(out_z_i) && $stable(out_yaw_now_i))

  // The sequencer is busy right after it takes a command.
  `PYT_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_i, !in_ready_i)

  // Yaw always lands strictly inside one full turn.
  `PYT_ASSERT_IMP(a_yaw_range, out_valid_i, (out_yaw_now_i > -17'sd46080) && (out_yaw_now_i < 17'sd46080))

endmodule

bind planar_yaw_pose_transform pyt_checker u_pyt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_x_i       (out_o.out_x),
  .out_y_i       (out_o.out_y),
  .out_z_i       (out_o.out_z),
  .out_yaw_now_i (out_o.yaw_now)
);

// File: sim/tb_planar_yaw_pose_transform.sv
// Self-checking testbench for planar_yaw_pose_transform: directed table, then random
// command beats under random valid/ready gaps, checked against a pose predictor.
// Depends on pyt_pkg, pyt_in_if, pyt_out_if and the block's RTL.
`timescale 1ns / 100ps

module tb_planar_yaw_pose_transform;
  import pyt_pkg::*;

  // Angles in 1/128 degree, CORDIC seed in Q1.15.
  localparam longint DEG360    = 46080;
  localparam longint DEG180    = 23040;
  localparam longint DEG90     = 11520;
  localparam longint GAIN_Q15  = 19898;
  localparam longint Q_MAX     = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_MIN     = -64'sh0000_0000_8000_0000;

  // atan(2^-i) in 2^-20 degree
  localparam longint ATAN_DEG20 [0:23] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
    234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
    917, 458, 229, 115, 57, 29, 14, 7
  };

  // Index 3 is not a register; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  localparam int RANDOM_PER_PHASE = 270;
  localparam int HOLD_CYCLES      = 300;
  localparam int STALL_LIMIT      = 3000;
  localparam int TAIL_CYCLES      = 2 * NUM_ITER + 20;

  typedef struct {
    func_e                     func;
    logic signed [ANGLE_W-1:0] angle;
    logic signed [COORD_W-1:0] distance;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
  } pose_cmd_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [ANGLE_W-1:0] yaw;
  } pose_out_t;

  // Directed row: when fixed is set, the typed result replaces the prediction.
  typedef struct {
    func_e  func;
    int     angle;
    longint travel;
    longint px;
    longint py;
    longint pz;
    bit     fixed;
    longint fx;
    longint fy;
    longint fz;
    int     fyaw;
  } stim_row_t;

  stim_row_t directed_rows [0:24] = '{
    // position and a null rotate straight out of reset
    '{FUNC_POSITION, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{FUNC_ROTATE, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{FUNC_POINT, 0, 0, 'h10000, 'h20000, 'h30000, 0, 0, 0, 0, 0},
    // yaw wrap at both ends of the range, offsets still zero
    '{FUNC_ROTATE, 46079, 0, 0, 0, 0, 1, 0, 0, 0, 46079},
    '{FUNC_ROTATE, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{FUNC_ROTATE, -46079, 0, 0, 0, 0, 1, 0, 0, 0, -46079},
    '{FUNC_ROTATE, -1, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    // deltas outside the stated range; other fields must be ignored
    '{FUNC_ROTATE, 65535, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1, 0, 0, 0, 19455},
    '{FUNC_ROTATE, -65536, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1, 0, 0, 0, -1},
    '{FUNC_ROTATE, 1, 0, 0, 0, 0, 1, 0, 0, 0, 0},
    // moves at extreme distances and folded elevations; offsets saturate
    '{FUNC_MOVE, 0, Q_MAX, 0, 0, 0, 0, 0, 0, 0, 0},
    '{FUNC_MOVE, 11520, Q_MAX, 0, 0, 0, 0, 0, 0, 0, 0},
    '{FUNC_MOVE, -65536, Q_MIN, 0, 0, 0, 0, 0, 0, 0, 0},
    '{FUNC_MOVE, 23040, Q_MIN, 0, 0, 0, 0, 0, 0, 0, 0},
    '{FUNC_MOVE, 65535, Q_MAX, 0, 0, 0, 0, 0, 0, 0, 0},
    '{FUNC_POINT, 0, 0, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 0, 0},
    '{FUNC_POINT, 0, 0, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 0},
    '{FUNC_ROTATE, 11520, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{FUNC_POINT, 0, 0, 'h12345678, -'h0ABCDEF0, 'h00FF00FF, 0, 0, 0, 0, 0},
    '{FUNC_ROTATE, 23040, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{FUNC_POINT, 0, 0, 'h10000, 'h20000, -'h30000, 0, 0, 0, 0, 0},
    '{FUNC_ROTATE, -11521, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{FUNC_MOVE, -11521, 'h10000, 0, 0, 0, 0, 0, 0, 0, 0},
    '{FUNC_POSITION, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{FUNC_MOVE, -46079, 'h400000, 0, 0, 0, 0, 0, 0, 0, 0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [COORD_W-1:0]   cfg_data;

  pyt_in_if  cmd_ch ();
  pyt_out_if res_ch ();

  planar_yaw_pose_transform dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (cmd_ch),
    .out_o      (res_ch)
  );

  // Predictor state: mirrors the pose held inside the block.
  longint model_yaw;
  longint model_offset [3];
  longint model_center [3];

  pose_out_t expected_poses [$];
  int        mismatch_cnt = 0;
  int        quiet_cycles = 0;
  bit        hold_req = 1'b0;
  bit        tx_steady = 1'b0;
  bit        rx_steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp16(input longint v);
    return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
  endfunction

  function automatic longint clamp32(input longint v);
    return (v > Q_MAX) ? Q_MAX : ((v < Q_MIN) ? Q_MIN : v);
  endfunction

  // Q1.15 times Q1.15 or Q16.16, floor shift by 15
  function automatic longint mul_q15(input longint a, input longint b);
    return (a * b) >>> 15;
  endfunction

  // Reduce to [-90, 90] degrees, folding through 180 with cosine negated,
  // then run the rotation-mode CORDIC on z in 2^-20 degree.
  function automatic void sin_cos_q15(input longint ang, output longint sn,
                                      output longint cs);
    longint r;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    bit     flip;
    r = ang % DEG360;
    if (r < 0) r += DEG360;
    if (r >= DEG180) r -= DEG360;
    flip = 1'b0;
    if (r > DEG90) begin
      r = DEG180 - r;
      flip = 1'b1;
    end else if (r < -DEG90) begin
      r = -DEG180 - r;
      flip = 1'b1;
    end
    z = r * 8192;
    x = GAIN_Q15;
    y = 0;
    for (int i = 0; i < NUM_ITER; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= ATAN_DEG20[i];
      end else begin
        x += dx;
        y -= dy;
        z += ATAN_DEG20[i];
      end
    end
    x = clamp16(x);
    y = clamp16(y);
    sn = y;
    cs = flip ? clamp16(-x) : x;
  endfunction

  // Advance the pose by one command and return the result beat it yields.
  function automatic pose_out_t pose_model_step(input pose_cmd_t c);
    pose_out_t r;
    longint    ang;
    longint    travel;
    longint    sy;
    longint    cy;
    longint    se;
    longint    ce;
    longint    rx;
    longint    ry;
    longint    dir [3];
    longint    res [3];
    ang    = longint'(c.angle);
    travel = longint'(c.distance);
    for (int k = 0; k < 3; k++) res[k] = model_offset[k];
    case (c.func)
      FUNC_ROTATE: begin
        model_yaw += ang;
        while (model_yaw >= DEG360) model_yaw -= DEG360;
        while (model_yaw <= -DEG360) model_yaw += DEG360;
      end
      FUNC_MOVE: begin
        sin_cos_q15(model_yaw, sy, cy);
        sin_cos_q15(ang, se, ce);
        dir[0] = clamp16(mul_q15(cy, ce));
        dir[1] = clamp16(mul_q15(sy, ce));
        dir[2] = se;
        for (int k = 0; k < 3; k++) begin
          model_offset[k] = clamp32(model_offset[k] + clamp32(mul_q15(dir[k], travel)));
          res[k] = model_offset[k];
        end
      end
      FUNC_POINT: begin
        sin_cos_q15(model_yaw, sy, cy);
        rx = clamp32(clamp32(mul_q15(cy, longint'(c.px))) -
                     clamp32(mul_q15(sy, longint'(c.py))));
        ry = clamp32(clamp32(mul_q15(sy, longint'(c.px))) +
                     clamp32(mul_q15(cy, longint'(c.py))));
        res[0] = clamp32(rx + model_offset[0]);
        res[1] = clamp32(ry + model_offset[1]);
        res[2] = clamp32(longint'(c.pz) + model_offset[2]);
      end
      default: begin
        for (int k = 0; k < 3; k++) res[k] = clamp32(model_center[k] + model_offset[k]);
      end
    endcase
    r.x   = res[0][COORD_W-1:0];
    r.y   = res[1][COORD_W-1:0];
    r.z   = res[2][COORD_W-1:0];
    r.yaw = model_yaw[ANGLE_W-1:0];
    return r;
  endfunction

  // Mostly small coordinates so saturated offsets can walk back; some full range.
  function automatic logic signed [COORD_W-1:0] random_coord();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) return int'($urandom_range(0, 2 ** 21)) - 2 ** 20;
    if (pick < 9) return int'($urandom_range(0, 2 ** 26)) - 2 ** 25;
    return $urandom;
  endfunction

  function automatic pose_cmd_t random_cmd();
    pose_cmd_t c;
    int        a;
    c.func = func_e'($urandom_range(0, 3));
    if ($urandom_range(0, 4) == 0) begin
      a = $urandom;
    end else begin
      a = int'($urandom_range(0, 92158)) - 46079;
    end
    c.angle    = a[ANGLE_W-1:0];
    c.distance = random_coord();
    c.px       = random_coord();
    c.py       = random_coord();
    c.pz       = random_coord();
    return c;
  endfunction

  // Offer one command beat after a random gap; predict once it is taken.
  task automatic send_cmd(input pose_cmd_t c, input bit fixed, input pose_out_t fixed_res);
    int        gap;
    pose_out_t pred;
    if ($urandom_range(0, 63) == 0) tx_steady = !tx_steady;
    gap = tx_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid    <= 1'b1;
    cmd_ch.func     <= c.func;
    cmd_ch.angle    <= c.angle;
    cmd_ch.distance <= c.distance;
    cmd_ch.point_x  <= c.px;
    cmd_ch.point_y  <= c.py;
    cmd_ch.point_z  <= c.pz;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    pred = pose_model_step(c);
    expected_poses.insert(expected_poses.size(), fixed ? fixed_res : pred);
  endtask

  // Drop valid and wait until every pending result beat has come back.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (expected_poses.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    if (idx != CFG_UNUSED_IDX) model_center[idx] = longint'($signed(data));
    @(posedge clk);
  endtask

  // Block is idle here; also poke the unused index, which must change nothing.
  task automatic set_centers(input logic [COORD_W-1:0] cx, input logic [COORD_W-1:0] cy,
                             input logic [COORD_W-1:0] cz);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_UNUSED_IDX, $urandom);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(input int count);
    pose_out_t none;
    none = '{default: '0};
    repeat (count) send_cmd(random_cmd(), 1'b0, none);
  endtask

  // Stimulus: reset, directed table, then random phases with the centers at
  // max, min, random and zero. The min phase starts with a long receiver
  // hold-off so the output register and the sequencer both fill up.
  initial begin : stimulus
    pose_cmd_t c;
    pose_out_t fixed_res;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    cmd_ch.valid    = 1'b0;
    cmd_ch.func     = '0;
    cmd_ch.angle    = '0;
    cmd_ch.distance = '0;
    cmd_ch.point_x  = '0;
    cmd_ch.point_y  = '0;
    cmd_ch.point_z  = '0;
    model_yaw       = 0;
    for (int k = 0; k < 3; k++) begin
      model_offset[k] = 0;
      model_center[k] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      c.func        = directed_rows[i].func;
      c.angle       = directed_rows[i].angle[ANGLE_W-1:0];
      c.distance    = directed_rows[i].travel[COORD_W-1:0];
      c.px          = directed_rows[i].px[COORD_W-1:0];
      c.py          = directed_rows[i].py[COORD_W-1:0];
      c.pz          = directed_rows[i].pz[COORD_W-1:0];
      fixed_res.x   = directed_rows[i].fx[COORD_W-1:0];
      fixed_res.y   = directed_rows[i].fy[COORD_W-1:0];
      fixed_res.z   = directed_rows[i].fz[COORD_W-1:0];
      fixed_res.yaw = directed_rows[i].fyaw[ANGLE_W-1:0];
      send_cmd(c, directed_rows[i].fixed, fixed_res);
    end
    drain();

    set_centers(Q_MAX[COORD_W-1:0], Q_MAX[COORD_W-1:0], Q_MAX[COORD_W-1:0]);
    run_random(RANDOM_PER_PHASE);
    drain();

    set_centers(Q_MIN[COORD_W-1:0], Q_MIN[COORD_W-1:0], Q_MIN[COORD_W-1:0]);
    hold_req = 1'b1;
    run_random(RANDOM_PER_PHASE);
    drain();

    set_centers($urandom, $urandom, $urandom);
    run_random(RANDOM_PER_PHASE);
    drain();

    set_centers('0, '0, '0);
    run_random(RANDOM_PER_PHASE);
    drain();

    // Catch any stray result beat after the last expected one.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("** planar_yaw_pose_transform: PASSED **");
    end else begin
      $display("** planar_yaw_pose_transform: FAILED **");
    end
    $finish;
  end

  // Result sink: random ready gaps, a single long hold-off on request,
  // and a field-by-field compare of each beat against the oldest prediction.
  initial begin : result_sink
    int        gap;
    pose_out_t e;
    res_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_steady = !rx_steady;
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 15);
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (res_ch.valid !== 1'b1);
      if (expected_poses.size() == 0) begin
        $error("result beat with no command pending");
        mismatch_cnt++;
      end else begin
        e = expected_poses.pop_front();
        if (res_ch.out_x !== e.x) begin
          $error("out_x: expected %0d, got %0d", e.x, res_ch.out_x);
          mismatch_cnt++;
        end
        if (res_ch.out_y !== e.y) begin
          $error("out_y: expected %0d, got %0d", e.y, res_ch.out_y);
          mismatch_cnt++;
        end
        if (res_ch.out_z !== e.z) begin
          $error("out_z: expected %0d, got %0d", e.z, res_ch.out_z);
          mismatch_cnt++;
        end
        if (res_ch.yaw_now !== e.yaw) begin
          $error("yaw_now: expected %0d, got %0d", e.yaw, res_ch.yaw_now);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("** planar_yaw_pose_transform: FAILED **");
        $finish;
      end
    end
  end

endmodule
